// ----- src/plc_pkg.sv -----
// Shared types, constants and helpers for the polar circle rasterizer.
// Used by the controller, the datapath and the divider; depends on nothing.
package plc_pkg;

    localparam int COORD_BITS       = 12;
    localparam int PIX_BITS         = COORD_BITS + 2;
    localparam int RAD_W            = 16;
    localparam int RADIUS_FRAC_BITS = 4;
    localparam int ANGLE_FRAC_BITS  = 30;
    localparam int POINT_FRAC_BITS  = 14 + RADIUS_FRAC_BITS;
    localparam int OFS_W            = 32 - POINT_FRAC_BITS + 1;
    localparam int FRAC_W           = ANGLE_FRAC_BITS + 1;
    localparam int DIV_W            = ANGLE_FRAC_BITS + RADIUS_FRAC_BITS + 1;
    localparam int DIVR_W           = RAD_W;
    localparam int COLOR_W          = 24;
    localparam int COS_TERMS        = 6;
    localparam int SIN_TERMS        = 5;

    localparam logic REQ_START   = 1'b0;
    localparam logic REQ_ADVANCE = 1'b1;

    typedef enum logic [4:0] {
        OP_NONE,
        OP_LOAD,
        OP_ZERO_PT,
        OP_DIV_T,
        OP_T_LOAD,
        OP_MUL_TT,
        OP_T2_LOAD,
        OP_MUL_TERM,
        OP_DIV_TERM,
        OP_TERM_ACC,
        OP_COS_STORE,
        OP_SIN_STORE,
        OP_ROT_XC,
        OP_ROT_YS,
        OP_ROT_YC,
        OP_ROT_XS,
        OP_ROT_END,
        OP_ROT_ROUND
    } t_dp_op;

    typedef struct packed {
        t_dp_op     op;
        logic [2:0] k;
        logic       sin_phase;
        logic [2:0] idx;
    } t_dp_cmd;

    typedef struct packed {
        logic req_adv;
        logic rad_zero;
        logic div_busy;
        logic arc_done;
    } t_dp_status;

    typedef struct packed {
        logic [2:0]  pre;
        logic [5:0]  post;
        logic [31:0] mult;
    } t_term_recip;

    // Series term divisors are split into a power of two and an odd factor.
    // The odd factor is divided by a rounded-up reciprocal, exact for the
    // 30-bit dividends that remain after the power-of-two shift.
    function automatic t_term_recip term_recip(input logic sin_phase,
                                               input logic [2:0] k);
        t_term_recip r;
        begin
            r.pre  = 3'd1;
            r.post = 6'd30;
            r.mult = 32'(64'd1 << 30);
            unique case ({sin_phase, k})
                {1'b0, 3'd1}: begin
                    r.pre = 3'd1; r.post = 6'd30; r.mult = 32'(64'd1 << 30);
                end
                {1'b0, 3'd2}: begin
                    r.pre = 3'd2; r.post = 6'd32;
                    r.mult = 32'(((64'd1 << 32) + 64'd2) / 64'd3);
                end
                {1'b0, 3'd3}: begin
                    r.pre = 3'd1; r.post = 6'd34;
                    r.mult = 32'(((64'd1 << 34) + 64'd14) / 64'd15);
                end
                {1'b0, 3'd4}: begin
                    r.pre = 3'd3; r.post = 6'd33;
                    r.mult = 32'(((64'd1 << 33) + 64'd6) / 64'd7);
                end
                {1'b0, 3'd5}: begin
                    r.pre = 3'd1; r.post = 6'd36;
                    r.mult = 32'(((64'd1 << 36) + 64'd44) / 64'd45);
                end
                {1'b0, 3'd6}: begin
                    r.pre = 3'd2; r.post = 6'd36;
                    r.mult = 32'(((64'd1 << 36) + 64'd32) / 64'd33);
                end
                {1'b1, 3'd1}: begin
                    r.pre = 3'd1; r.post = 6'd32;
                    r.mult = 32'(((64'd1 << 32) + 64'd2) / 64'd3);
                end
                {1'b1, 3'd2}: begin
                    r.pre = 3'd2; r.post = 6'd33;
                    r.mult = 32'(((64'd1 << 33) + 64'd4) / 64'd5);
                end
                {1'b1, 3'd3}: begin
                    r.pre = 3'd1; r.post = 6'd35;
                    r.mult = 32'(((64'd1 << 35) + 64'd20) / 64'd21);
                end
                {1'b1, 3'd4}: begin
                    r.pre = 3'd3; r.post = 6'd34;
                    r.mult = 32'(((64'd1 << 34) + 64'd8) / 64'd9);
                end
                {1'b1, 3'd5}: begin
                    r.pre = 3'd1; r.post = 6'd36;
                    r.mult = 32'(((64'd1 << 36) + 64'd54) / 64'd55);
                end
                default: begin
                    r.pre = 3'd1; r.post = 6'd30; r.mult = 32'(64'd1 << 30);
                end
            endcase
            term_recip = r;
        end
    endfunction

endpackage

// ----- src/polar_circle_rasterizer.sv -----
// Top level of the polar circle rasterizer.
// Depends on plc_pkg, plc_ctrl and plc_datapath.
//
// Each request on the slave stream either starts a circle (tuser 0) or
// advances it one rotation step (tuser 1). A start computes 1/r by a serial
// divider and then cosine and sine by an eleven-term series, each term two
// multiplies on the shared multiplier, the second by a constant reciprocal.
// The master stream then carries eight symmetric pixels, one per cycle while
// the receiver is ready, tlast on the eighth; tuser is set on the eighth pixel
// of the request that completes the circle.
// A start runs the divider for 1/r and then the series terms. An advance runs
// the rotation on the shared multiplier, then the output. An advance with no
// circle active produces no pixels and the block returns to idle.
// One request is handled at a time: tready is high only while the block is idle.
// When the receiver stalls, the current pixel holds until it is taken.
// Reset returns to idle with no circle active and the color set to red.
// The color register may be written only while the block is idle.
module polar_circle_rasterizer (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [39:0] i_s_axis_tdata,  // center_x[11:0], center_y[23:12], radius[39:24]
    input  logic        i_s_axis_tuser,  // req_type
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    output logic [55:0] o_m_axis_tdata,  // pixel_x[13:0], pixel_y[27:14], color[51:28], zero pad
    output logic        o_m_axis_tlast,
    output logic        o_m_axis_tuser,  // circle_done
    input  logic        i_cfg_wr_en,
    input  logic [23:0] i_cfg_wr_data
);
    import plc_pkg::*;

    t_dp_cmd              cmd;
    t_dp_status           status;
    logic [PIX_BITS-1:0]  pix_x, pix_y;
    logic [COLOR_W-1:0]   color;

    plc_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_s_axis_tvalid),
        .o_in_ready  (o_s_axis_tready),
        .o_out_valid (o_m_axis_tvalid),
        .i_out_ready (i_m_axis_tready),
        .o_out_last  (o_m_axis_tlast),
        .o_out_done  (o_m_axis_tuser),
        .i_status    (status),
        .o_cmd       (cmd)
    );

    plc_datapath u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (cmd),
        .i_center_x    (i_s_axis_tdata[11:0]),
        .i_center_y    (i_s_axis_tdata[23:12]),
        .i_radius      (i_s_axis_tdata[39:24]),
        .i_req_type    (i_s_axis_tuser),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .o_status      (status),
        .o_pixel_x     (pix_x),
        .o_pixel_y     (pix_y),
        .o_color       (color)
    );

    assign o_m_axis_tdata = {4'b0, color, pix_y, pix_x};
endmodule

// ----- src/plc_div.sv -----
// Restoring unsigned divider, one quotient bit per cycle.
// Depends on plc_pkg for its widths.
module plc_div (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_start,
    input  logic [plc_pkg::DIV_W-1:0]   i_dividend,
    input  logic [plc_pkg::DIVR_W-1:0]  i_divisor,
    output logic                        o_busy,
    output logic [plc_pkg::DIV_W-1:0]   o_quotient
);
    import plc_pkg::*;

    localparam int CNT_W = $clog2(DIV_W + 1);

    logic [DIV_W-1:0]  r_dq;
    logic [DIVR_W-1:0] r_rem;
    logic [DIVR_W-1:0] r_dvs;
    logic [CNT_W-1:0]  r_cnt;
    logic              r_busy;
    logic [DIVR_W:0]   rem_sh;
    logic              fits;

    assign rem_sh = {r_rem, r_dq[DIV_W-1]};
    assign fits   = rem_sh >= {1'b0, r_dvs};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_cnt  <= CNT_W'(DIV_W);
            r_dq   <= i_dividend;
            r_rem  <= '0;
            r_dvs  <= i_divisor;
        end else if (r_busy) begin
            r_rem <= fits ? DIVR_W'(rem_sh - {1'b0, r_dvs}) : rem_sh[DIVR_W-1:0];
            r_dq  <= {r_dq[DIV_W-2:0], fits};
            r_cnt <= r_cnt - 1'b1;
            if (r_cnt == CNT_W'(1)) begin
                r_busy <= 1'b0;
            end
        end
    end

    assign o_busy     = r_busy;
    assign o_quotient = r_dq;
endmodule

// ----- src/plc_datapath.sv -----
// Datapath: point and trig registers, shared multiplier, divider, pixel output.
// Depends on plc_pkg and plc_div; driven by commands from plc_ctrl.
module plc_datapath (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  plc_pkg::t_dp_cmd              i_cmd,
    input  logic [plc_pkg::COORD_BITS-1:0] i_center_x,
    input  logic [plc_pkg::COORD_BITS-1:0] i_center_y,
    input  logic [plc_pkg::RAD_W-1:0]     i_radius,
    input  logic                          i_req_type,
    input  logic                          i_cfg_wr_en,
    input  logic [plc_pkg::COLOR_W-1:0]   i_cfg_wr_data,
    output plc_pkg::t_dp_status           o_status,
    output logic [plc_pkg::PIX_BITS-1:0]  o_pixel_x,
    output logic [plc_pkg::PIX_BITS-1:0]  o_pixel_y,
    output logic [plc_pkg::COLOR_W-1:0]   o_color
);
    import plc_pkg::*;

    localparam int A = ANGLE_FRAC_BITS;
    localparam int SUM_W = COORD_BITS + 5;
    localparam int PIX_LO = -(1 << COORD_BITS);
    localparam int PIX_HI = (1 << (COORD_BITS + 1)) - 1;

    logic [COORD_BITS-1:0] r_cx, r_cy;
    logic [RAD_W-1:0]      r_rad;
    logic                  r_req;
    logic [COLOR_W-1:0]    r_color;
    logic [FRAC_W-1:0]     r_t, r_t2, r_term;
    logic [31:0]           r_sum, r_cos, r_sin, r_px, r_py, r_nx;
    logic signed [63:0]    r_prod, r_acc;
    logic signed [OFS_W-1:0] r_a, r_b;

    logic signed [31:0]    mul_a, mul_b;
    logic                  div_start, div_busy;
    logic [DIV_W-1:0]      div_dividend, div_quot;
    logic [DIVR_W-1:0]     div_divisor;
    logic [63:0]           rot_sum, rot_dif;
    logic [32:0]           rnd_x, rnd_y;
    t_term_recip           recip;
    logic [FRAC_W-1:0]     term_q;

    plc_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (div_dividend),
        .i_divisor  (div_divisor),
        .o_busy     (div_busy),
        .o_quotient (div_quot)
    );

    assign recip  = term_recip(i_cmd.sin_phase, i_cmd.k);
    assign term_q = FRAC_W'(r_prod >> recip.post);

    always_comb begin
        mul_a = '0;
        mul_b = '0;
        case (i_cmd.op)
            OP_MUL_TT:   begin mul_a = 32'(r_t);    mul_b = 32'(r_t);  end
            OP_MUL_TERM: begin mul_a = 32'(r_term); mul_b = 32'(r_t2); end
            OP_DIV_TERM: begin
                mul_a = 32'(r_prod[A+FRAC_W-1:A] >> recip.pre);
                mul_b = recip.mult;
            end
            OP_ROT_XC:   begin mul_a = r_px; mul_b = r_cos; end
            OP_ROT_YS:   begin mul_a = r_py; mul_b = r_sin; end
            OP_ROT_YC:   begin mul_a = r_py; mul_b = r_cos; end
            OP_ROT_XS:   begin mul_a = r_px; mul_b = r_sin; end
            default:     begin mul_a = '0;   mul_b = '0;    end
        endcase
    end

    assign div_start    = (i_cmd.op == OP_DIV_T);
    assign div_dividend = DIV_W'(1) << (DIV_W - 1);
    assign div_divisor  = r_rad;

    assign rot_sum = r_acc + r_prod;
    assign rot_dif = r_acc - r_prod;
    assign rnd_x   = {r_px[31], r_px} + 33'(1 << (POINT_FRAC_BITS - 1));
    assign rnd_y   = {r_py[31], r_py} + 33'(1 << (POINT_FRAC_BITS - 1));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_color <= 24'hFF0000;
            r_px    <= '0;
            r_py    <= '0;
            r_cos   <= '0;
            r_sin   <= '0;
            r_cx    <= '0;
            r_cy    <= '0;
        end else begin
            if (i_cfg_wr_en) begin
                r_color <= i_cfg_wr_data;
            end
            r_prod <= mul_a * mul_b;
            case (i_cmd.op)
                OP_LOAD: begin
                    r_req <= i_req_type;
                    if (i_req_type == REQ_START) begin
                        r_cx <= i_center_x;
                        r_cy <= i_center_y;
                        if (i_radius == '0) begin
                            r_rad <= '0;
                        end else if (i_radius < RAD_W'(1 << RADIUS_FRAC_BITS)) begin
                            r_rad <= RAD_W'(1 << RADIUS_FRAC_BITS);
                        end else begin
                            r_rad <= i_radius;
                        end
                    end
                end
                OP_ZERO_PT: begin
                    r_px <= '0;
                    r_py <= '0;
                    r_a  <= '0;
                    r_b  <= '0;
                end
                OP_T_LOAD: begin
                    r_t    <= div_quot[FRAC_W-1:0];
                    r_term <= FRAC_W'(1) << A;
                    r_sum  <= 32'(1) << A;
                end
                OP_T2_LOAD: r_t2 <= r_prod[A+FRAC_W-1:A];
                OP_TERM_ACC: begin
                    r_term <= term_q;
                    r_sum  <= i_cmd.k[0] ? r_sum - 32'(term_q)
                                         : r_sum + 32'(term_q);
                end
                OP_COS_STORE: begin
                    r_cos  <= r_sum;
                    r_term <= r_t;
                    r_sum  <= 32'(r_t);
                end
                OP_SIN_STORE: begin
                    r_sin <= r_sum;
                    r_px  <= '0;
                    r_py  <= 32'(r_rad) << (POINT_FRAC_BITS - RADIUS_FRAC_BITS);
                    r_a   <= '0;
                    r_b   <= OFS_W'(r_rad >> RADIUS_FRAC_BITS);
                end
                OP_ROT_YS: r_acc <= r_prod;
                OP_ROT_YC: r_nx  <= rot_sum[A+31:A];
                OP_ROT_XS: r_acc <= r_prod;
                OP_ROT_END: begin
                    r_px <= r_nx;
                    r_py <= rot_dif[A+31:A];
                end
                OP_ROT_ROUND: begin
                    r_a <= rnd_x[32:POINT_FRAC_BITS];
                    r_b <= rnd_y[32:POINT_FRAC_BITS];
                end
                default: ;
            endcase
        end
    end

    logic signed [OFS_W-1:0] ofs_x, ofs_y, sel_x, sel_y;
    logic signed [SUM_W-1:0] sum_x, sum_y;

    function automatic logic [PIX_BITS-1:0] sat_pix(input logic signed [SUM_W-1:0] v);
        begin
            if (v < PIX_LO) begin
                sat_pix = PIX_BITS'(PIX_LO);
            end else if (v > PIX_HI) begin
                sat_pix = PIX_BITS'(PIX_HI);
            end else begin
                sat_pix = v[PIX_BITS-1:0];
            end
        end
    endfunction

    always_comb begin
        sel_x = i_cmd.idx[2] ? r_b : r_a;
        sel_y = i_cmd.idx[2] ? r_a : r_b;
        ofs_x = i_cmd.idx[1] ? -sel_x : sel_x;
        ofs_y = i_cmd.idx[0] ? -sel_y : sel_y;
        sum_x = $signed({{(SUM_W-COORD_BITS){1'b0}}, r_cx}) + SUM_W'(ofs_x);
        sum_y = $signed({{(SUM_W-COORD_BITS){1'b0}}, r_cy}) + SUM_W'(ofs_y);
    end

    assign o_pixel_x = sat_pix(sum_x);
    assign o_pixel_y = sat_pix(sum_y);
    assign o_color   = r_color;

    assign o_status.req_adv  = r_req;
    assign o_status.rad_zero = (r_rad == '0);
    assign o_status.div_busy = div_busy;
    assign o_status.arc_done = $signed(r_px) >= $signed(r_py);
endmodule

// ----- src/plc_ctrl.sv -----
// Controller: sequences the trig series, the rotation and the eight-pixel output.
// Depends on plc_pkg; drives plc_datapath through a command struct.
module plc_ctrl (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output logic                o_out_last,
    output logic                o_out_done,
    input  plc_pkg::t_dp_status i_status,
    output plc_pkg::t_dp_cmd    o_cmd
);
    import plc_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE, S_DECODE, S_DIVT, S_SQR, S_SQR2, S_TMUL, S_TDIV, S_TWAIT,
        S_TNEXT, S_ROT1, S_ROT2, S_ROT3, S_ROT4, S_ROT5, S_EMIT
    } t_state;

    t_state     r_state, n_state;
    logic [2:0] r_k, n_k, r_idx, n_idx;
    logic       r_sin, n_sin, r_active, n_active, r_done, n_done;

    always_comb begin
        n_state   = r_state;
        n_k       = r_k;
        n_idx     = r_idx;
        n_sin     = r_sin;
        n_active  = r_active;
        n_done    = r_done;
        o_cmd.op        = OP_NONE;
        o_cmd.k         = r_k;
        o_cmd.sin_phase = r_sin;
        o_cmd.idx       = r_idx;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.op = OP_LOAD;
                    n_state  = S_DECODE;
                end
            end
            S_DECODE: begin
                if (!i_status.req_adv) begin
                    if (i_status.rad_zero) begin
                        o_cmd.op = OP_ZERO_PT;
                        n_active = 1'b0;
                        n_done   = 1'b1;
                        n_idx    = '0;
                        n_state  = S_EMIT;
                    end else begin
                        o_cmd.op = OP_DIV_T;
                        n_state  = S_DIVT;
                    end
                end else if (r_active) begin
                    o_cmd.op = OP_ROT_XC;
                    n_state  = S_ROT1;
                end else begin
                    n_state = S_IDLE;
                end
            end
            S_DIVT: begin
                if (!i_status.div_busy) begin
                    o_cmd.op = OP_T_LOAD;
                    n_state  = S_SQR;
                end
            end
            S_SQR: begin
                o_cmd.op = OP_MUL_TT;
                n_state  = S_SQR2;
            end
            S_SQR2: begin
                o_cmd.op = OP_T2_LOAD;
                n_k      = 3'd1;
                n_sin    = 1'b0;
                n_state  = S_TMUL;
            end
            S_TMUL: begin
                o_cmd.op = OP_MUL_TERM;
                n_state  = S_TDIV;
            end
            S_TDIV: begin
                o_cmd.op = OP_DIV_TERM;
                n_state  = S_TWAIT;
            end
            S_TWAIT: begin
                if (!i_status.div_busy) begin
                    o_cmd.op = OP_TERM_ACC;
                    n_state  = S_TNEXT;
                end
            end
            S_TNEXT: begin
                if (!r_sin && r_k == 3'(COS_TERMS)) begin
                    o_cmd.op = OP_COS_STORE;
                    n_k      = 3'd1;
                    n_sin    = 1'b1;
                    n_state  = S_TMUL;
                end else if (r_sin && r_k == 3'(SIN_TERMS)) begin
                    o_cmd.op = OP_SIN_STORE;
                    n_active = 1'b1;
                    n_done   = 1'b0;
                    n_idx    = '0;
                    n_state  = S_EMIT;
                end else begin
                    n_k     = r_k + 3'd1;
                    n_state = S_TMUL;
                end
            end
            S_ROT1: begin
                o_cmd.op = OP_ROT_YS;
                n_state  = S_ROT2;
            end
            S_ROT2: begin
                o_cmd.op = OP_ROT_YC;
                n_state  = S_ROT3;
            end
            S_ROT3: begin
                o_cmd.op = OP_ROT_XS;
                n_state  = S_ROT4;
            end
            S_ROT4: begin
                o_cmd.op = OP_ROT_END;
                n_state  = S_ROT5;
            end
            S_ROT5: begin
                o_cmd.op = OP_ROT_ROUND;
                n_done   = i_status.arc_done;
                if (i_status.arc_done) begin
                    n_active = 1'b0;
                end
                n_idx   = '0;
                n_state = S_EMIT;
            end
            S_EMIT: begin
                if (i_out_ready) begin
                    if (r_idx == 3'd7) begin
                        n_state = S_IDLE;
                    end else begin
                        n_idx = r_idx + 3'd1;
                    end
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_k      <= '0;
            r_idx    <= '0;
            r_sin    <= 1'b0;
            r_active <= 1'b0;
            r_done   <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_k      <= n_k;
            r_idx    <= n_idx;
            r_sin    <= n_sin;
            r_active <= n_active;
            r_done   <= n_done;
        end
    end

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = (r_state == S_EMIT);
    assign o_out_last  = (r_idx == 3'd7);
    assign o_out_done  = r_done && (r_idx == 3'd7);
endmodule
